[hw/rtl/mod_pkg.sv]
`timescale 1ns / 1ps
// mod_pkg: shared types, S-box and round helpers for the OPc derivation block.
// No dependencies.
package mod_pkg;

  localparam int unsigned HalfW   = 64;
  localparam int unsigned BlockW  = 128;
  localparam int unsigned NRounds = 10;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] REG_OP_HIGH = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_OP_LOW  = 1'b1;

  typedef struct packed {
    logic [HalfW-1:0] ki_high;
    logic [HalfW-1:0] ki_low;
  } in_item_t;

  typedef struct packed {
    logic [HalfW-1:0] opc_high;
    logic [HalfW-1:0] opc_low;
  } out_item_t;

  // one pipeline slot: running state, running round key, OP for the final xor
  typedef struct packed {
    logic [BlockW-1:0] st;
    logic [BlockW-1:0] rk;
    logic [BlockW-1:0] op;
  } slot_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte n of a block, n = 0 is the first byte (bits 127:120)
  function automatic logic [7:0] byte_of(input logic [BlockW-1:0] b, input int n);
    return b[BlockW-1-8*n -: 8];
  endfunction

endpackage

[hw/rtl/mod_round.sv]
`timescale 1ns / 1ps
// mod_round: one registered AES-128 round plus its key expansion step.
// Depends on mod_pkg.
module mod_round
  import mod_pkg::*;
#(
  parameter logic [3:0] Round = 4'd1
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  vld_in,
  input  slot_t slot_in,
  output logic  vld_out,
  output slot_t slot_out
);

  logic              vld_r;
  slot_t             slot_r;
  logic [BlockW-1:0] sr, mc, rk_n;
  logic [31:0]       tw;

  always_comb begin
    // SubBytes and ShiftRows: out byte r+4c takes in byte r+4((c+r)&3)
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[BlockW-1-8*(r+4*c) -: 8] = sbox(byte_of(slot_in.st, r + 4*((c + r) & 3)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = byte_of(sr, 4*c);
      a1 = byte_of(sr, 4*c + 1);
      a2 = byte_of(sr, 4*c + 2);
      a3 = byte_of(sr, 4*c + 3);
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[BlockW-1-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                                 a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
    end
    // key schedule: next four words from the current round key
    tw = {sbox(slot_in.rk[23:16]) ^ rcon(Round), sbox(slot_in.rk[15:8]),
          sbox(slot_in.rk[7:0]), sbox(slot_in.rk[31:24])};
    rk_n[127:96] = slot_in.rk[127:96] ^ tw;
    rk_n[95:64]  = slot_in.rk[95:64] ^ rk_n[127:96];
    rk_n[63:32]  = slot_in.rk[63:32] ^ rk_n[95:64];
    rk_n[31:0]   = slot_in.rk[31:0] ^ rk_n[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slot_r.st <= ((Round == 4'(NRounds)) ? sr : mc) ^ rk_n;
      slot_r.rk <= rk_n;
      slot_r.op <= slot_in.op;
    end
  end

  assign vld_out  = vld_r;
  assign slot_out = slot_r;

endmodule

[hw/rtl/milenage_opc_derive_top.sv]
`timescale 1ns / 1ps
// milenage_opc_derive_top: OPc = AES-128_Ki(OP) xor OP, one round per stage.
// Depends on mod_pkg and mod_round.
//
// Usage:
//   cfg_*  : write OP (index 0 high half, 1 low half) while the block is idle.
//            Writes to any other index are dropped.
//   in_*   : one Ki per transaction, valid/ready.
//   out_*  : one OPc per transaction, valid/ready.
// Pipeline: an input register with the initial key add, ten round stages, and
// an output register holding the final OP xor: twelve registers in a row.
// Throughput is one transaction per cycle, set by the round stages, while
// the receiver does not stall the output register.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stalled receiver freezes every stage and nothing is
// lost or repeated. in_ready drops whenever the output holds an untaken
// result and out_ready is low, whether or not the stages behind it are full.
// Reset clears every valid bit and sets OP to zero.
module milenage_opc_derive_top
  import mod_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_item_t                 out_data,
  input  logic                      cfg_we,
  input  logic [CfgIdxW:0]          cfg_index,
  input  logic [HalfW-1:0]          cfg_wdata
);

  logic [HalfW-1:0] op_high_r, op_low_r;
  logic             en;
  logic             vld [NRounds+1];
  slot_t            slot [NRounds+1];
  logic             s0_vld_r;
  slot_t            s0_r;
  logic             o_vld_r;
  out_item_t        o_r;
  logic [BlockW-1:0] opc;

  // config: index is one bit wider than needed so out-of-range writes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_high_r <= '0;
      op_low_r  <= '0;
    end else if (cfg_we && !cfg_index[CfgIdxW]) begin
      if (cfg_index[CfgIdxW-1:0] == REG_OP_HIGH) op_high_r <= cfg_wdata;
      if (cfg_index[CfgIdxW-1:0] == REG_OP_LOW)  op_low_r  <= cfg_wdata;
    end
  end

  // global advance: output slot free or being drained
  assign en       = !o_vld_r || out_ready;
  assign in_ready = en;

  // stage 0: initial AddRoundKey
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r.st <= {op_high_r, op_low_r} ^ {in_data.ki_high, in_data.ki_low};
      s0_r.rk <= {in_data.ki_high, in_data.ki_low};
      s0_r.op <= {op_high_r, op_low_r};
    end
  end

  assign vld[0]  = s0_vld_r;
  assign slot[0] = s0_r;

  for (genvar g = 0; g < NRounds; g++) begin : g_round
    mod_round #(.Round(4'(g + 1))) u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .vld_in   (vld[g]),
      .slot_in  (slot[g]),
      .vld_out  (vld[g+1]),
      .slot_out (slot[g+1])
    );
  end

  assign opc = slot[NRounds].st ^ slot[NRounds].op;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= vld[NRounds];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_r.opc_high <= opc[BlockW-1:HalfW];
      o_r.opc_low  <= opc[HalfW-1:0];
    end
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_r;

endmodule
